/* rtl/sfir_pkg.sv */
// Shared constants, state encoding and control structs for the stereo FIR low-pass filter.
// Every other file in this folder imports this package.
package sfir_pkg;

  localparam int MAX_TAPS       = 512;
  localparam int ADDR_W         = $clog2(MAX_TAPS);
  localparam int NCNT_W         = ADDR_W + 1;
  localparam int TAP_W          = 10;
  localparam int MIN_TAPS       = 3;
  localparam int SAMPLE_W       = 16;
  localparam int COEF_W         = 31;
  localparam int COEF_FRAC_BITS = 16;
  localparam int PROD_W         = SAMPLE_W + COEF_W;
  localparam int TERM_W         = PROD_W - COEF_FRAC_BITS;
  localparam int ACC_W          = TERM_W + ADDR_W + 1;
  localparam int DIV_SHIFT      = 4;
  localparam int DIVD_W         = ACC_W - 1 - DIV_SHIFT;
  localparam int DCNT_W         = $clog2(DIVD_W);

  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_DIV,
    ST_PUSH
  } sfir_state_t;

  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctrl_t;

  typedef struct packed {
    logic start;
    logic neg;
  } div_ctrl_t;

endpackage

/* rtl/stereo_fir_lowpass.sv */
// Top level of the stereo FIR low-pass filter: sequencer, delay and coefficient memories.
// Depends on sfir_pkg, sfir_mac and sfir_div.
//
// Input items arrive on in_valid/in_stall. Opcode 0 filters one sample, opcode 1 writes
// one coefficient. Result items leave on out_valid/out_stall, one per filtered sample.
// The tap_count register is written over cfg_valid/cfg_ready; the user must write it
// only while the block is idle, as the block itself does not enforce it; a write clears
// both delay lines. In bypass (tap_count below 3) a sample skips the multiply-accumulate
// and divide steps. A filtered sample passes once per tap through the single
// multiply-accumulate unit, drains its pipeline, goes through the serial divider (one
// quotient bit per cycle for 36 bits), loads the output register and returns to idle.
// in_stall is high while a sample is being processed. A finished result waits in an
// output register while the next item is accepted; if that register is still held
// by out_stall when the next result is ready, the sequencer waits for it.
// Reset clears the register to zero, the fill counts, head pointers and channel toggle.
// Delay entries not yet written since reset or a register write read as zero through
// a per-channel fill count, so no clearing pass is needed.
module stereo_fir_lowpass (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 opcode,
  input  logic signed [sfir_pkg::SAMPLE_W-1:0] sample,
  input  logic        [sfir_pkg::ADDR_W-1:0]   coef_index,
  input  logic        [sfir_pkg::COEF_W-1:0]   coef_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [sfir_pkg::SAMPLE_W-1:0] filtered,
  output logic                                 channel,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [sfir_pkg::TAP_W-1:0]    tap_count
);
  import sfir_pkg::*;

  sfir_state_t         state;
  sfir_state_t         state_next;
  logic [TAP_W-1:0]    taps;
  logic [NCNT_W-1:0]   n_eff;
  logic                bypass;
  logic                accept_in;
  logic                start_filter;
  logic                issue;
  logic                pipe_empty;
  logic                finish;
  logic                push;

  logic [ADDR_W-1:0]   head [2];
  logic [NCNT_W-1:0]   fill [2];
  logic                toggle;
  logic                ch;
  logic [ADDR_W-1:0]   h;
  logic [ADDR_W-1:0]   idx;
  logic [ADDR_W-1:0]   coef_addr;
  logic [NCNT_W-1:0]   remain;
  logic signed [SAMPLE_W-1:0] sample_hold;
  logic [NCNT_W-1:0]   h_plus;
  logic [NCNT_W-1:0]   idx_plus;

  logic [SAMPLE_W-1:0] delay_mem [2*MAX_TAPS];
  logic [COEF_W-1:0]   coef_mem [MAX_TAPS];
  logic [SAMPLE_W-1:0] delay_rd;
  logic [COEF_W-1:0]   coef_rd;
  logic                rd_valid;
  logic                rd_mask;

  mac_ctrl_t           mac_ctl;
  logic signed [SAMPLE_W-1:0] mac_sample;
  logic [ACC_W-1:0]    acc;
  logic                mac_busy;
  div_ctrl_t           div_ctl;
  logic [ACC_W-1:0]    acc_mag;
  logic                div_done;
  logic [SAMPLE_W-1:0] div_quot;

  logic signed [SAMPLE_W-1:0] res_filtered;
  logic                res_channel;

  assign n_eff        = (taps > TAP_W'(MAX_TAPS)) ? NCNT_W'(MAX_TAPS) : NCNT_W'(taps);
  assign bypass       = n_eff < NCNT_W'(MIN_TAPS);
  assign cfg_ready    = 1'b1;
  assign accept_in    = in_valid && !in_stall;
  assign start_filter = accept_in && (opcode == OP_FILTER) && !bypass;
  assign h_plus       = NCNT_W'(h) + 1'b1;
  assign idx_plus     = NCNT_W'(idx) + 1'b1;
  assign pipe_empty   = !rd_valid && !mac_busy;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept_in && (opcode == OP_FILTER)) begin
          state_next = bypass ? ST_PUSH : ST_MAC;
        end
      end
      ST_MAC: begin
        if (remain == NCNT_W'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    issue    = (state == ST_MAC);
    finish   = (state == ST_DRAIN) && pipe_empty;
    push     = (state == ST_PUSH) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      taps      <= '0;
      head[0]   <= '0;
      head[1]   <= '0;
      fill[0]   <= '0;
      fill[1]   <= '0;
      toggle    <= 1'b0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (cfg_valid && cfg_ready) begin
        taps    <= tap_count;
        head[0] <= '0;
        head[1] <= '0;
        fill[0] <= '0;
        fill[1] <= '0;
      end
      if (accept_in && (opcode == OP_FILTER) && bypass) begin
        toggle <= 1'b0;
      end
      if (finish) begin
        head[ch] <= (h_plus == n_eff) ? '0 : h_plus[ADDR_W-1:0];
        if (fill[ch] < n_eff) begin
          fill[ch] <= fill[ch] + 1'b1;
        end
        toggle <= ~ch;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in && (opcode == OP_FILTER)) begin
      sample_hold  <= sample;
      ch           <= toggle;
      h            <= head[toggle];
      idx          <= head[toggle];
      coef_addr    <= ADDR_W'(n_eff - 1'b1);
      remain       <= n_eff;
      res_filtered <= sample;
      res_channel  <= 1'b0;
    end
    if (issue) begin
      idx       <= (idx_plus == n_eff) ? '0 : idx_plus[ADDR_W-1:0];
      coef_addr <= coef_addr - 1'b1;
      remain    <= remain - 1'b1;
      rd_mask   <= NCNT_W'(idx) < fill[ch];
    end
    if (div_done) begin
      res_filtered <= div_quot;
      res_channel  <= ch;
    end
    if (push) begin
      filtered <= res_filtered;
      channel  <= res_channel;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      delay_rd <= delay_mem[{ch, idx}];
    end
    if (finish) begin
      delay_mem[{ch, h}] <= sample_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in && (opcode == OP_COEF)) begin
      coef_mem[coef_index] <= coef_value;
    end
    if (issue) begin
      coef_rd <= coef_mem[coef_addr];
    end
  end

  assign mac_ctl.clear = start_filter;
  assign mac_ctl.valid = rd_valid;
  assign mac_sample    = rd_mask ? delay_rd : '0;

  sfir_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .sample (mac_sample),
    .coef   (coef_rd),
    .acc    (acc),
    .busy   (mac_busy)
  );

  assign acc_mag       = acc[ACC_W-1] ? ACC_W'(-acc) : acc;
  assign div_ctl.start = finish;
  assign div_ctl.neg   = acc[ACC_W-1];

  sfir_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (acc_mag[ACC_W-2:DIV_SHIFT]),
    .divisor  (n_eff),
    .done     (div_done),
    .quot     (div_quot)
  );

`ifndef NO_ASSERTIONS
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("Divider finished outside the divide phase.");

  a_pipe_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!rd_valid && !mac_busy))
    else $error("Accumulator pipeline busy while idle.");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAC) |-> ((NCNT_W'(idx) < n_eff) && (NCNT_W'(h) < n_eff)))
    else $error("Delay line index beyond the filter length.");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    (fill[0] <= n_eff) && (fill[1] <= n_eff))
    else $error("Fill count exceeds the filter length.");

  a_push_once: assert property (@(posedge clk) disable iff (rst)
    push |=> (state == ST_IDLE) && out_valid)
    else $error("Result not presented after push.");
`endif

endmodule

/* rtl/sfir_mac.sv */
// Shared multiply-accumulate unit: one registered sample-by-coefficient product per cycle.
// Depends on sfir_pkg for widths and the control struct.
module sfir_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sfir_pkg::mac_ctrl_t                   ctl,
  input  logic signed [sfir_pkg::SAMPLE_W-1:0]  sample,
  input  logic        [sfir_pkg::COEF_W-1:0]    coef,
  output logic        [sfir_pkg::ACC_W-1:0]     acc,
  output logic                                  busy
);
  import sfir_pkg::*;

  logic [SAMPLE_W-1:0] mag;
  logic [PROD_W-1:0]   full;
  logic                prod_valid;
  logic                prod_neg;
  logic [TERM_W-1:0]   prod_mag;
  logic [ACC_W-1:0]    term;

  assign mag  = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);
  assign full = PROD_W'(mag) * PROD_W'(coef);
  assign term = {{(ACC_W-TERM_W){1'b0}}, prod_mag};
  assign busy = prod_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_neg <= sample[SAMPLE_W-1];
    prod_mag <= full[PROD_W-1:COEF_FRAC_BITS];
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= prod_neg ? acc - term : acc + term;
    end
  end

endmodule

/* rtl/sfir_div.sv */
// Restoring serial divider that produces one quotient bit per cycle, with sign applied at the end.
// Depends on sfir_pkg for widths and the control struct.
module sfir_div (
  input  logic                                clk,
  input  logic                                rst,
  input  sfir_pkg::div_ctrl_t                 ctl,
  input  logic [sfir_pkg::DIVD_W-1:0]         dividend,
  input  logic [sfir_pkg::NCNT_W-1:0]         divisor,
  output logic                                done,
  output logic [sfir_pkg::SAMPLE_W-1:0]       quot
);
  import sfir_pkg::*;

  logic              busy;
  logic [DCNT_W-1:0] count;
  logic [NCNT_W-1:0] rem;
  logic [NCNT_W-1:0] dvs;
  logic [DIVD_W-1:0] q;
  logic              neg;
  logic [NCNT_W:0]   trial;
  logic              ge;
  logic [NCNT_W:0]   diff;

  assign trial = {rem, q[DIVD_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};
  assign quot  = neg ? SAMPLE_W'(-q[SAMPLE_W-1:0]) : q[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (count == '0);
      if (ctl.start) begin
        busy <= 1'b1;
      end else if (busy && (count == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      q     <= dividend;
      rem   <= '0;
      dvs   <= divisor;
      neg   <= ctl.neg;
      count <= DCNT_W'(DIVD_W - 1);
    end else if (busy) begin
      rem   <= ge ? diff[NCNT_W-1:0] : trial[NCNT_W-1:0];
      q     <= {q[DIVD_W-2:0], ge};
      count <= count - 1'b1;
    end
  end

endmodule
